/* src/queued_tone_generator_top_defines.svh */
// ---------------------------------------------------------------------------
// Queued tone generator assertion macros
// Shared property shapes for the checks inside the tone generator modules.
// ---------------------------------------------------------------------------
`ifndef QUEUED_TONE_GENERATOR_TOP_DEFINES_SVH
`define QUEUED_TONE_GENERATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QTG_ASSERT_NOW(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Consequent must hold in the cycle after the antecedent.
`define QTG_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

/* src/qtg_pkg.sv */
// ---------------------------------------------------------------------------
// Queued tone generator package
// Widths, register codes, the classified item type and the sine table.
// ---------------------------------------------------------------------------
package qtg_pkg;

  // Field widths
  localparam int AMP_W    = 15;
  localparam int RATE_W   = 17;
  localparam int STEP_W   = 20;
  localparam int FREQ_W   = 15;
  localparam int DUR_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int INC_W    = 32;
  localparam int CNT_W    = 23;
  localparam int PHASE_W  = 32;
  localparam int TONE_W   = 15;
  localparam int TONE_FRAC = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE   = 2'd0,
    REG_SAMPLE_RATE = 2'd1,
    REG_PHASE_STEP  = 2'd2
  } cfg_reg_t;

  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd28000;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd97392;

  // Tone queue
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Item queue between front and back
  localparam int ITEM_FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(ITEM_FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(ITEM_FIFO_DEPTH + 1);

  // Milliseconds to samples: floor(dur * rate / 1000), with 1000 = 8 * 125.
  // The divide by 125 is a reciprocal multiply followed by one correction.
  localparam int DIV_SHIFT   = 3;
  localparam int DIV_ODD     = 125;
  localparam int DIV_ODD_W   = $clog2(DIV_ODD);
  localparam int PROD_W      = DUR_W + RATE_W;
  localparam int Q_W         = PROD_W - DIV_SHIFT;
  localparam int RECIP_SHIFT = Q_W + DIV_ODD_W;
  localparam int RECIP_W     = RECIP_SHIFT - DIV_ODD_W + 1;
  localparam int EST_W       = Q_W - DIV_ODD_W + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_ODD);

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    action_t          action;
    logic [INC_W-1:0] inc;
    logic [CNT_W-1:0] cnt;
  } qtg_item_t;

  // Quarter-wave sine table, Q0.15, entries 0 .. SINE_TABLE_ENTRIES
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int SINE_K_W    = $clog2(SINE_TABLE_ENTRIES);
  localparam int SINE_ADDR_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Factorial ratios (2n)(2n+1) between successive series terms.
  localparam logic [63:0] TAYLOR_DIV_1 = 64'(2 * 3);
  localparam logic [63:0] TAYLOR_DIV_2 = 64'(4 * 5);
  localparam logic [63:0] TAYLOR_DIV_3 = 64'(6 * 7);
  localparam logic [63:0] TAYLOR_DIV_4 = 64'(8 * 9);
  localparam logic [63:0] TAYLOR_DIV_5 = 64'(10 * 11);
  localparam logic [63:0] TAYLOR_DIV_6 = 64'(12 * 13);

  typedef logic [TONE_W-1:0] sine_rom_t [0:SINE_TABLE_ENTRIES];

  // Taylor series of sin(x) in Q30, seven terms, each truncated as it goes.
  function automatic logic [TONE_W-1:0] quarter_sine(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / TAYLOR_DIV_1;
        2:       term = term / TAYLOR_DIV_2;
        3:       term = term / TAYLOR_DIV_3;
        4:       term = term / TAYLOR_DIV_4;
        5:       term = term / TAYLOR_DIV_5;
        default: term = term / TAYLOR_DIV_6;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    return (r > 64'd32767) ? {TONE_W{1'b1}} : TONE_W'(r);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

endpackage

/* src/qtg_front.sv */
// ---------------------------------------------------------------------------
// Queued tone generator front end
// Accepts items, turns push parameters into a phase increment and a sample
// count, and hands classified items to the item queue.
// ---------------------------------------------------------------------------
module qtg_front import qtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [FREQ_W-1:0]     in_tone_freq_hz,
  input  logic [DUR_W-1:0]      in_duration_ms,
  input  logic [RATE_W-1:0]     sample_rate,
  input  logic [STEP_W-1:0]     phase_step_per_hz,
  input  logic [FIFO_CNT_W-1:0] fifo_level,
  output logic                  wr_valid,
  output qtg_item_t             wr_item
);

  logic                          f1_valid_r;
  action_t                       f1_action_r;
  logic [INC_W-1:0]              f1_inc_r;
  logic [PROD_W-1:0]             f1_prod_r;

  logic                          f2_valid_r;
  action_t                       f2_action_r;
  logic [INC_W-1:0]              f2_inc_r;
  logic [Q_W-1:0]                f2_q_r;
  logic [EST_W-1:0]              f2_est_r;

  logic [FREQ_W+STEP_W-1:0]      inc_full;
  logic [PROD_W-1:0]             dur_prod;
  logic [Q_W-1:0]                q;
  logic [Q_W+RECIP_W-1:0]        recip_prod;
  logic [EST_W+DIV_ODD_W-1:0]    est_x_odd;
  logic [Q_W-1:0]                rem;
  logic                          fix;
  logic [EST_W-1:0]              cnt_full;
  logic [FIFO_CNT_W+1:0]         occupancy;

  // Every item in the two front stages already holds a slot in the queue,
  // so the front never has to stall.
  always_comb begin
    occupancy = (FIFO_CNT_W+2)'(fifo_level) + (FIFO_CNT_W+2)'(f1_valid_r)
              + (FIFO_CNT_W+2)'(f2_valid_r);
    in_ready  = (occupancy < (FIFO_CNT_W+2)'(ITEM_FIFO_DEPTH));
  end

  always_comb begin
    inc_full   = in_tone_freq_hz * phase_step_per_hz;
    dur_prod   = in_duration_ms * sample_rate;
    q          = f1_prod_r[PROD_W-1:DIV_SHIFT];
    recip_prod = q * DIV_RECIP;
  end

  // The estimate is the quotient or one short of it.
  always_comb begin
    est_x_odd = {{DIV_ODD_W{1'b0}}, f2_est_r} * (EST_W+DIV_ODD_W)'(DIV_ODD);
    rem       = f2_q_r - est_x_odd[Q_W-1:0];
    fix       = (rem >= Q_W'(DIV_ODD));
    cnt_full  = f2_est_r + EST_W'(fix);
    wr_valid  = f2_valid_r;
    wr_item.action = f2_action_r;
    wr_item.inc    = f2_inc_r;
    if (cnt_full > EST_W'(COUNT_MAX)) begin
      wr_item.cnt = COUNT_MAX;
    end else begin
      wr_item.cnt = cnt_full[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= in_valid && in_ready;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_action_r <= action_t'(in_action);
    f1_inc_r    <= inc_full[INC_W-1:0];
    f1_prod_r   <= dur_prod;
    f2_action_r <= f1_action_r;
    f2_inc_r    <= f1_inc_r;
    f2_q_r      <= q;
    f2_est_r    <= recip_prod[RECIP_SHIFT +: EST_W];
  end

endmodule

/* src/qtg_fifo.sv */
// ---------------------------------------------------------------------------
// Queued tone generator item queue
// Short queue of classified items between the front end and the back end.
// ---------------------------------------------------------------------------
`include "queued_tone_generator_top_defines.svh"

module qtg_fifo import qtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  input  qtg_item_t             wr_item,
  input  logic                  rd_pop,
  output qtg_item_t             rd_item,
  output logic                  empty,
  output logic [FIFO_CNT_W-1:0] level
);

  qtg_item_t               mem_q [ITEM_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic [FIFO_CNT_W-1:0]   count_nxt;

  always_comb begin
    rd_item = mem_q[rd_ptr_r];
    empty   = (count_r == '0);
    level   = count_r;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_valid) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(ITEM_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(ITEM_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_valid && !rd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_valid && rd_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem_q[wr_ptr_r] <= wr_item;
    end
  end

  // The front end reserves a slot before it accepts an item.
  `QTG_ASSERT_NOW(a_fifo_no_overflow, clk, rst_n, wr_valid,
                  count_r < FIFO_CNT_W'(ITEM_FIFO_DEPTH), "item queue overflow")
  `QTG_ASSERT_NOW(a_fifo_no_underflow, clk, rst_n, rd_pop,
                  count_r != '0, "item queue read while empty")

endmodule

/* src/qtg_back.sv */
// ---------------------------------------------------------------------------
// Queued tone generator back end
// Runs queued items against the tone queue and the oscillator, then looks up
// the sine table and scales the sample through a three-stage pipeline.
// ---------------------------------------------------------------------------
`include "queued_tone_generator_top_defines.svh"

module qtg_back import qtg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [AMP_W-1:0]           amplitude,
  input  logic                       fifo_empty,
  input  qtg_item_t                  fifo_item,
  output logic                       fifo_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_busy_res,
  output logic                       out_dropped
);

  typedef struct packed {
    logic live;
    logic neg;
    logic busy;
    logic dropped;
  } stage_stat_t;

  localparam sine_rom_t SineRom = build_sine_rom();

  // Tone queue storage, written only at the tail.
  logic [INC_W-1:0]          tone_inc_q [QUEUE_DEPTH];
  logic [CNT_W-1:0]          tone_cnt_q [QUEUE_DEPTH];

  logic [QIDX_W-1:0]         head_r;
  logic [QIDX_W-1:0]         head_nxt;
  logic [QFILL_W-1:0]        fill_r;
  logic [QFILL_W-1:0]        fill_nxt;
  logic [CNT_W-1:0]          used_r;
  logic [CNT_W-1:0]          used_nxt;
  logic [PHASE_W-1:0]        phase_r;
  logic [PHASE_W-1:0]        phase_nxt;

  logic                      s1_valid_r;
  stage_stat_t               s1_stat_r;
  stage_stat_t               s1_stat_nxt;
  logic [TONE_W-1:0]         tone_r;
  logic                      s2_valid_r;
  stage_stat_t               s2_stat_r;
  logic [AMP_W+TONE_W-1:0]   prod_r;
  logic                      out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                      out_busy_r;
  logic                      out_dropped_r;

  logic                      adv;
  logic                      take;
  logic                      tail_wr;
  logic [QIDX_W:0]           tail_sum;
  logic [QIDX_W-1:0]         tail;
  logic [INC_W-1:0]          head_inc;
  logic [CNT_W-1:0]          head_cnt;
  logic [CNT_W-1:0]          used_inc;
  logic [1:0]                quad;
  logic [SINE_K_W-1:0]       k;
  logic [SINE_ADDR_W-1:0]    rom_addr;
  logic [TONE_W-1:0]         mag;
  logic [SAMPLE_W-1:0]       mag_ext;

  // The whole pipeline moves whenever the output register can take a result.
  assign adv      = !out_valid_r || out_ready;
  assign take     = adv && !fifo_empty;
  assign fifo_pop = take;

  always_comb begin
    head_inc = tone_inc_q[head_r];
    head_cnt = tone_cnt_q[head_r];
    used_inc = used_r + 1'b1;
    tail_sum = (QIDX_W+1)'(head_r) + (QIDX_W+1)'(fill_r);
    if (tail_sum >= (QIDX_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QIDX_W+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[QIDX_W-1:0];

    head_nxt    = head_r;
    fill_nxt    = fill_r;
    used_nxt    = used_r;
    phase_nxt   = phase_r;
    tail_wr     = 1'b0;
    s1_stat_nxt = '0;

    // Table address comes from the phase before this tick advances it.
    quad     = phase_r[PHASE_W-1 -: 2];
    k        = phase_r[PHASE_W-3 -: SINE_K_W];
    rom_addr = quad[0] ? SINE_ADDR_W'(SINE_TABLE_ENTRIES) - {1'b0, k} : {1'b0, k};
    s1_stat_nxt.neg = quad[1];

    if (take) begin
      if (fifo_item.action == ACT_PUSH) begin
        // A tone of zero samples is ignored without a drop flag.
        if (fifo_item.cnt != '0) begin
          if (fill_r == QFILL_W'(QUEUE_DEPTH)) begin
            s1_stat_nxt.dropped = 1'b1;
          end else begin
            tail_wr  = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
      end else if (fill_r != '0) begin
        s1_stat_nxt.live = 1'b1;
        phase_nxt = phase_r + head_inc;
        if (used_inc == head_cnt) begin
          head_nxt = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          fill_nxt = fill_r - 1'b1;
          used_nxt = '0;
        end else begin
          used_nxt = used_inc;
        end
      end
    end
    s1_stat_nxt.busy = (fill_nxt != '0);
  end

  always_comb begin
    mag     = prod_r[AMP_W+TONE_W-1:TONE_FRAC];
    mag_ext = {{(SAMPLE_W-TONE_W){1'b0}}, mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      used_r      <= '0;
      phase_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      used_r  <= used_nxt;
      phase_r <= phase_nxt;
      if (adv) begin
        s1_valid_r  <= take;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_stat_r <= s1_stat_nxt;
      tone_r    <= SineRom[rom_addr];
      s2_stat_r <= s1_stat_r;
      prod_r    <= amplitude * tone_r;
      out_busy_r    <= s2_stat_r.busy;
      out_dropped_r <= s2_stat_r.dropped;
      if (!s2_stat_r.live) begin
        out_sample_r <= '0;
      end else if (s2_stat_r.neg) begin
        out_sample_r <= signed'(SAMPLE_W'(-mag_ext));
      end else begin
        out_sample_r <= signed'(mag_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_wr) begin
      tone_inc_q[tail] <= fifo_item.inc;
      tone_cnt_q[tail] <= fifo_item.cnt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_busy_res = out_busy_r;
  assign out_dropped  = out_dropped_r;

  `QTG_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1,
                  fill_r <= QFILL_W'(QUEUE_DEPTH), "tone queue fill above depth")
  `QTG_ASSERT_NOW(a_head_count, clk, rst_n, fill_r != '0,
                  used_r < tone_cnt_q[head_r], "head tone used past its length")
  `QTG_ASSERT_NOW(a_drop_busy, clk, rst_n, out_valid_r && out_dropped_r,
                  out_busy_r, "dropped push reported with an empty queue")
  `QTG_ASSERT_NEXT(a_phase_hold, clk, rst_n, !s1_stat_nxt.live,
                   $stable(phase_r), "phase moved without a sounding tick")

endmodule

/* src/queued_tone_generator_top.sv */
// ---------------------------------------------------------------------------
// Queued tone generator
// Tone queue feeding a phase-accumulator sine oscillator, one result per item.
//
//   channel  direction  ports                                   moves
//   in       input      in_valid/in_ready, action, freq, dur    push or tick
//   out      output     out_valid/out_ready, sample, busy, drop one result
//   cfg      input      cfg_valid/cfg_ready, cfg_index, data    register write
//
// Sustains one item per clock while out_ready holds; out_valid follows the input
// accept through two front stages and the item queue, then three back stages.
// The front reserves an item queue slot per accepted item, so in_ready
// depends only on registers; out_ready stalls only the back pipeline.
// Reset is synchronous; no clearing pass is needed after it.
// ---------------------------------------------------------------------------
module queued_tone_generator_top import qtg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [FREQ_W-1:0]          in_tone_freq_hz,
  input  logic [DUR_W-1:0]           in_duration_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_busy_res,
  output logic                       out_dropped,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic [AMP_W-1:0]      amplitude_r;
  logic [RATE_W-1:0]     sample_rate_r;
  logic [STEP_W-1:0]     phase_step_r;

  logic                  fifo_wr;
  qtg_item_t             fifo_wr_item;
  logic                  fifo_pop;
  qtg_item_t             fifo_rd_item;
  logic                  fifo_empty;
  logic [FIFO_CNT_W-1:0] fifo_level;

  assign cfg_ready = 1'b1;

  // Writes to an index past the last register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r   <= AMP_RESET;
      sample_rate_r <= RATE_RESET;
      phase_step_r  <= STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AMPLITUDE:   amplitude_r   <= cfg_data[AMP_W-1:0];
        REG_SAMPLE_RATE: sample_rate_r <= cfg_data[RATE_W-1:0];
        REG_PHASE_STEP:  phase_step_r  <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qtg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_tone_freq_hz   (in_tone_freq_hz),
    .in_duration_ms    (in_duration_ms),
    .sample_rate       (sample_rate_r),
    .phase_step_per_hz (phase_step_r),
    .fifo_level        (fifo_level),
    .wr_valid          (fifo_wr),
    .wr_item           (fifo_wr_item)
  );

  qtg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fifo_wr),
    .wr_item  (fifo_wr_item),
    .rd_pop   (fifo_pop),
    .rd_item  (fifo_rd_item),
    .empty    (fifo_empty),
    .level    (fifo_level)
  );

  qtg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .amplitude    (amplitude_r),
    .fifo_empty   (fifo_empty),
    .fifo_item    (fifo_rd_item),
    .fifo_pop     (fifo_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_busy_res (out_busy_res),
    .out_dropped  (out_dropped)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Queued tone generator testbench
// Drives push and tick items through the valid/ready input, checks every
// sample, busy and drop flag against a cycle-free model of the tone queue
// and sine oscillator, and steps through several register settings.
// ---------------------------------------------------------------------------
module testbench;
  import qtg_pkg::*;

  localparam int MAX_GAP       = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 24;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int PLAN_ROWS     = 23;
  localparam int NUM_PHASES    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       busy;
    logic                       drop;
  } tone_result_t;

  typedef struct packed {
    logic [INC_W-1:0] inc;
    logic [CNT_W-1:0] left;
  } tone_slot_t;

  typedef enum logic {
    ROW_ITEM  = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    action_t               act;
    logic [FREQ_W-1:0]     freq;
    logic [DUR_W-1:0]      dur;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  typed;
    tone_result_t          want;
  } plan_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] amp_word;
    logic [CFG_DATA_W-1:0] rate_word;
    logic [CFG_DATA_W-1:0] step_word;
    logic [15:0]           items;
    logic [DUR_W-1:0]      dur_top;
    logic [7:0]            long_pct;
    logic                  send_burst;
    logic                  recv_burst;
    logic                  hold;
  } phase_plan_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_action = ACT_PUSH;
  logic [FREQ_W-1:0]          in_tone_freq_hz = '0;
  logic [DUR_W-1:0]           in_duration_ms = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_busy_res;
  logic                       out_dropped;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Model state: tone queue, oscillator phase and register copies.
  tone_slot_t        tones [QUEUE_DEPTH];
  int                q_head = 0;
  int                q_fill = 0;
  logic [PHASE_W-1:0] osc_phase = '0;
  logic [AMP_W-1:0]  cur_amp = AMP_RESET;
  logic [RATE_W-1:0] cur_rate = RATE_RESET;
  logic [STEP_W-1:0] cur_step = STEP_RESET;
  logic [TONE_W-1:0] sine_tab [0:SINE_TABLE_ENTRIES];

  tone_result_t synth_due [$];

  plan_row_t   plan [PLAN_ROWS];
  phase_plan_t phases [NUM_PHASES];

  logic send_burst = 1'b0;
  logic recv_burst = 1'b0;
  logic stall_pending = 1'b0;

  int cycle_count = 0;
  int err_count = 0;
  int n_results = 0;
  int n_ticks = 0;
  int n_pushes = 0;
  int n_dropped = 0;
  int n_played = 0;
  int n_settings = 1;

  queued_tone_generator_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_tone_freq_hz (in_tone_freq_hz),
    .in_duration_ms  (in_duration_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_busy_res    (out_busy_res),
    .out_dropped     (out_dropped),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, synth_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Quarter-wave table: Taylor series of sin(x) in Q30, truncating each term.
  initial begin : build_sine
    longint unsigned ang;
    longint unsigned pw;
    longint unsigned scaled;
    longint          acc;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      ang = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
      pw  = ang;
      acc = $signed(ang);
      for (int n = 1; n <= 6; n++) begin
        pw = (pw * ang) >> 30;
        pw = (pw * ang) >> 30;
        pw = pw / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - $signed(pw);
        end else begin
          acc = acc + $signed(pw);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      scaled = ($unsigned(acc) * 64'd32767 + 64'd536870912) >> 30;
      sine_tab[k] = (scaled > 64'd32767) ? '1 : scaled[TONE_W-1:0];
    end
  end

  // One item through the tone queue and oscillator; returns its result.
  function automatic tone_result_t synth_next(input action_t act,
                                              input logic [FREQ_W-1:0] f,
                                              input logic [DUR_W-1:0] d);
    tone_result_t      r;
    longint unsigned   span;
    longint unsigned   lookup;
    int                quad;
    int                k;
    int                slot;
    logic [TONE_W-1:0] tv;
    logic [15:0]       mag;
    r = '0;
    if (act == ACT_PUSH) begin
      span = (64'(d) * 64'(cur_rate)) / 64'd1000;
      if (span > 64'(COUNT_MAX)) begin
        span = 64'(COUNT_MAX);
      end
      if (span != 0) begin
        if (q_fill >= QUEUE_DEPTH) begin
          r.drop = 1'b1;
          n_dropped++;
        end else begin
          slot = (q_head + q_fill) % QUEUE_DEPTH;
          tones[slot].inc  = INC_W'(64'(f) * 64'(cur_step));
          tones[slot].left = span[CNT_W-1:0];
          q_fill++;
        end
      end
    end else if (q_fill != 0) begin
      lookup = (64'(osc_phase) * 64'(4 * SINE_TABLE_ENTRIES)) >> 32;
      quad   = int'(lookup / SINE_TABLE_ENTRIES);
      k      = int'(lookup % SINE_TABLE_ENTRIES);
      tv     = (quad % 2 == 1) ? sine_tab[SINE_TABLE_ENTRIES - k] : sine_tab[k];
      mag    = 16'((64'(cur_amp) * 64'(tv)) >> 15);
      r.smp  = (quad >= 2) ? -mag : mag;
      osc_phase = osc_phase + tones[q_head].inc;
      if (tones[q_head].left != 0) begin
        tones[q_head].left = tones[q_head].left - 1'b1;
      end
      if (tones[q_head].left == 0) begin
        q_head = (q_head + 1) % QUEUE_DEPTH;
        q_fill--;
        n_played++;
      end
    end
    r.busy = (q_fill != 0);
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic drive_item(input action_t act, input logic [FREQ_W-1:0] f,
                            input logic [DUR_W-1:0] d, input logic typed,
                            input tone_result_t fixed);
    int           gap;
    tone_result_t res;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_tone_freq_hz <= f;
    in_duration_ms  <= d;
    do @(posedge clk); while (!in_ready);
    res = synth_next(act, f, d);
    synth_due.push_back(typed ? fixed : res);
    if (act == ACT_TICK) begin
      n_ticks++;
    end else begin
      n_pushes++;
    end
  endtask

  // Stops offering items and waits until the block has nothing in flight.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (synth_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AMPLITUDE:   cur_amp  = data[AMP_W-1:0];
      REG_SAMPLE_RATE: cur_rate = data[RATE_W-1:0];
      REG_PHASE_STEP:  cur_step = data[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int           gap;
    tone_result_t want;
    wait (rst_n);
    forever begin
      gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      // The long hold-off lets the block fill up and push back on its input.
      if (stall_pending) begin
        gap = HOLD_CYCLES;
        stall_pending = 1'b0;
      end
      @(negedge clk);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_results++;
      if (synth_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
      end else begin
        want = synth_due.pop_front();
        if (out_sample !== want.smp) begin
          flag_mismatch($sformatf("result %0d sample %0d, expected %0d",
                                  n_results, out_sample, want.smp));
        end
        if (out_busy_res !== want.busy) begin
          flag_mismatch($sformatf("result %0d busy %b, expected %b",
                                  n_results, out_busy_res, want.busy));
        end
        if (out_dropped !== want.drop) begin
          flag_mismatch($sformatf("result %0d dropped %b, expected %b",
                                  n_results, out_dropped, want.drop));
        end
      end
    end
  end

  initial begin : stimulus
    action_t           act;
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0]  d;
    int                tick_pct;

    // Directed items: empty queue, zero-length tone, queue filled to the brim.
    plan = '{
      '{ROW_ITEM,  ACT_TICK, 15'd0,     16'd0,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b0, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd0,     16'd0,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b0, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd24000, 16'd1,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_TICK, 15'd0,     16'd0,     REG_AMPLITUDE,   20'd0,    1'b0, '0},
      '{ROW_ITEM,  ACT_TICK, 15'h7FFF,  16'hFFFF,  REG_AMPLITUDE,   20'd0,    1'b0, '0},
      '{ROW_WRITE, ACT_TICK, 15'd0,     16'd0,     REG_SAMPLE_RATE, 20'd1000, 1'b0, '0},
      '{ROW_ITEM,  ACT_PUSH, 15'd1,     16'd1,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd440,   16'd2,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd1000,  16'd3,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'h5555,  16'd1,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'h2AAA,  16'd2,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd12000, 16'd3,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd20000, 16'd1,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd3,     16'd2,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd99,    16'd3,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd7777,  16'd1,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd24000, 16'd2,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd16384, 16'd3,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd8191,  16'd1,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'd2,     16'd2,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'h7FFF,  16'd2,     REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_ITEM,  ACT_PUSH, 15'h7FFF,  16'hFFFF,  REG_AMPLITUDE,   20'd0,    1'b1,
        '{16'sd0, 1'b1, 1'b1}},
      '{ROW_ITEM,  ACT_TICK, 15'h7FFF,  16'd0,     REG_AMPLITUDE,   20'd0,    1'b0, '0}
    };

    // Settings include masked writes: amplitude 1, a rate of zero and the
    // largest rate the register holds, which saturates long tones.
    phases = '{
      '{20'd32767,   20'd8000,    20'd536871,  16'd230, 16'd2, 8'd0,   1'b0, 1'b0, 1'b0},
      '{20'h08001,   20'd2000,    20'hFFFFF,   16'd230, 16'd3, 8'd0,   1'b1, 1'b0, 1'b1},
      '{20'd0,       20'd96000,   20'd44739,   16'd150, 16'd1, 8'd0,   1'b0, 1'b1, 1'b0},
      '{20'd28000,   20'h20000,   20'd0,       16'd60,  16'd1, 8'd100, 1'b1, 1'b1, 1'b0},
      '{20'd16384,   20'd44100,   20'd97392,   16'd200, 16'd1, 8'd0,   1'b0, 1'b0, 1'b0},
      '{20'd12000,   20'd3000,    20'd987654,  16'd250, 16'd5, 8'd0,   1'b0, 1'b1, 1'b0},
      '{20'hFFFFF,   20'hFFFFF,   20'd654321,  16'd150, 16'd1, 8'd3,   1'b0, 1'b0, 1'b0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
        n_settings++;
      end else begin
        drive_item(plan[i].act, plan[i].freq, plan[i].dur, plan[i].typed, plan[i].want);
      end
    end

    foreach (phases[p]) begin
      wait_idle();
      write_reg(REG_AMPLITUDE, phases[p].amp_word);
      write_reg(REG_SAMPLE_RATE, phases[p].rate_word);
      write_reg(REG_PHASE_STEP, phases[p].step_word);
      write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
      n_settings++;
      send_burst = phases[p].send_burst;
      recv_burst = phases[p].recv_burst;
      if (phases[p].hold) begin
        stall_pending = 1'b1;
      end
      repeat (phases[p].items) begin
        // Lean toward ticks as the queue fills so that tones get played out
        // and the head wraps, while a full queue still sees pushes.
        if (q_fill >= QUEUE_DEPTH - 2) begin
          tick_pct = 85;
        end else if (q_fill <= 1) begin
          tick_pct = 30;
        end else begin
          tick_pct = 55;
        end
        act = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_PUSH;
        f   = FREQ_W'($urandom_range(0, (1 << FREQ_W) - 1));
        if ($urandom_range(0, 99) < phases[p].long_pct) begin
          d = DUR_W'($urandom_range(0, (1 << DUR_W) - 1));
        end else begin
          d = DUR_W'($urandom_range(0, phases[p].dur_top));
        end
        drive_item(act, f, d, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks and %0d pushes, %0d pushes dropped on a full queue.",
             n_ticks, n_pushes, n_dropped);
    $display("%0d tones played out under %0d register settings, %0d results, %0d mismatches.",
             n_played, n_settings, n_results, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
